[rtl/lmlg_pkg.sv]
// shared types, constants and tables for the list marker label generator
package lmlg_pkg;

	localparam int DEF_MAX_DEPTH = 8;
	localparam int DEF_ID_WIDTH  = 16;
	localparam int CNT_W         = 31;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [15:0] GL_DISC   = 16'h2022;
	localparam logic [15:0] GL_CIRCLE = 16'h25E6;
	localparam logic [15:0] GL_SQUARE = 16'h25AA;
	localparam logic [15:0] GL_DASH   = 16'h2013;
	localparam logic [15:0] CH_DOT    = 16'h002E;

	// style codes
	localparam logic [3:0] ST_DEC    = 4'd0;
	localparam logic [3:0] ST_LALPHA = 4'd1;
	localparam logic [3:0] ST_UALPHA = 4'd2;
	localparam logic [3:0] ST_LROMAN = 4'd3;
	localparam logic [3:0] ST_UROMAN = 4'd4;
	localparam logic [3:0] ST_DISC   = 4'd5;
	localparam logic [3:0] ST_CIRCLE = 4'd6;
	localparam logic [3:0] ST_SQUARE = 4'd7;
	localparam logic [3:0] ST_DASH   = 4'd8;

	// conversion modes for the digit unit
	typedef enum logic [1:0] {
		MD_DEC   = 2'd0,
		MD_ALPHA = 2'd1,
		MD_ROMAN = 2'd2
	} mode_t;

	// request from the control to the digit unit
	typedef struct packed {
		logic            start;
		mode_t           mode;
		logic            upper;
		logic [CNT_W-1:0] value;
	} conv_req_t;

	// status back from the digit unit
	typedef struct packed {
		logic        done;
		logic [4:0]  count;
	} conv_sts_t;

	// roman table: value and up to two letters (upper case ascii)
	function automatic logic [9:0] rn_val(input logic [3:0] r);
		case (r)
			4'd0: rn_val = 10'd1000;
			4'd1: rn_val = 10'd900;
			4'd2: rn_val = 10'd500;
			4'd3: rn_val = 10'd400;
			4'd4: rn_val = 10'd100;
			4'd5: rn_val = 10'd90;
			4'd6: rn_val = 10'd50;
			4'd7: rn_val = 10'd40;
			4'd8: rn_val = 10'd10;
			4'd9: rn_val = 10'd9;
			4'd10: rn_val = 10'd5;
			4'd11: rn_val = 10'd4;
			default: rn_val = 10'd1;
		endcase
	endfunction

	// two symbols packed {second, first}; second zero when absent
	function automatic logic [13:0] rn_sym(input logic [3:0] r);
		case (r)
			4'd0: rn_sym = {7'd0, 7'h4D};
			4'd1: rn_sym = {7'h4D, 7'h43};
			4'd2: rn_sym = {7'd0, 7'h44};
			4'd3: rn_sym = {7'h44, 7'h43};
			4'd4: rn_sym = {7'd0, 7'h43};
			4'd5: rn_sym = {7'h43, 7'h58};
			4'd6: rn_sym = {7'd0, 7'h4C};
			4'd7: rn_sym = {7'h4C, 7'h58};
			4'd8: rn_sym = {7'd0, 7'h58};
			4'd9: rn_sym = {7'h58, 7'h49};
			4'd10: rn_sym = {7'd0, 7'h56};
			4'd11: rn_sym = {7'h56, 7'h49};
			default: rn_sym = {7'd0, 7'h49};
		endcase
	endfunction

endpackage

[rtl/lmlg_conv.sv]
// digit unit: one roman step a cycle or multiply then remainder per digit, into a buffer
module lmlg_conv import lmlg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  conv_req_t        req,
	output conv_sts_t        sts,
	input  logic [3:0]       rd_idx,
	output logic [15:0]      rd_char
);

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_MUL  = 5'b00010,
		C_REM  = 5'b00100,
		C_ROM  = 5'b01000,
		C_DONE = 5'b10000
	} cst_t;

	// reciprocals: n/10 = (n*M10)>>35, n/26 = ((n>>1)*M13)>>34, exact below 2^31
	localparam logic [31:0] M10 = 32'hCCCCCCCD;
	localparam logic [31:0] M13 = 32'd1321528400;

	cst_t              st_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  quo_q;
	logic [4:0]        k_q;
	mode_t             mode_q;
	logic              upper_q;
	logic [3:0]        r_q;
	logic [6:0]        buf_q [16];

	// shared multiplier and remainder
	logic [CNT_W-1:0] mul_a;
	logic [31:0]      mul_b;
	logic [62:0]      prod;
	logic [CNT_W-1:0] quo;
	logic [4:0]       dvs;
	logic [4:0]       rem;
	logic [9:0]       rv;
	logic [13:0]      sym;
	logic [6:0]       ccase;
	logic [6:0]       dchar;
	logic [CNT_W-1:0] nm1;

	assign mul_a = (mode_q == MD_ALPHA) ? {1'b0, n_q[CNT_W-1:1]} : n_q;
	assign mul_b = (mode_q == MD_ALPHA) ? M13 : M10;
	assign prod  = {32'd0, mul_a} * {31'd0, mul_b};
	assign quo   = (mode_q == MD_ALPHA) ? {2'b0, prod[62:34]} : {3'b0, prod[62:35]};
	assign dvs   = (mode_q == MD_ALPHA) ? 5'd26 : 5'd10;
	assign rem   = n_q[4:0] - 5'(quo_q[4:0] * dvs);
	assign rv    = rn_val(r_q);
	assign sym   = rn_sym(r_q);
	assign ccase = upper_q ? 7'd0 : 7'd32;
	assign nm1   = req.value - 1'b1;
	assign dchar = (mode_q == MD_ALPHA) ? (7'h41 + ccase + {2'b0, rem}) : (7'h30 + {2'b0, rem});

	// character buffer readout, digits were stored lowest first for divide modes
	always_comb begin
		logic [3:0] a;
		a = (mode_q == MD_ROMAN) ? rd_idx : 4'(k_q - 5'd1 - {1'b0, rd_idx});
		rd_char = {9'd0, buf_q[a]};
	end

	assign sts.done  = (st_q == C_DONE);
	assign sts.count = k_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			k_q  <= '0;
		end else begin
			unique case (st_q)
				C_IDLE: begin
					if (req.start) begin
						k_q     <= '0;
						upper_q <= req.upper;
						r_q     <= '0;
						if (req.mode == MD_ROMAN && req.value < CNT_W'(4000)) begin
							mode_q <= MD_ROMAN;
							n_q    <= req.value;
							st_q   <= C_ROM;
						end else if (req.mode == MD_ALPHA) begin
							mode_q <= MD_ALPHA;
							n_q    <= nm1;
							st_q   <= C_MUL;
						end else begin
							mode_q <= MD_DEC;
							n_q    <= req.value;
							st_q   <= C_MUL;
						end
					end
				end
				C_MUL: begin
					quo_q <= quo;
					st_q  <= C_REM;
				end
				C_REM: begin
					// digit complete
					buf_q[k_q[3:0]] <= dchar;
					k_q <= k_q + 5'd1;
					if (quo_q == '0) begin
						st_q <= C_DONE;
					end else begin
						n_q  <= (mode_q == MD_ALPHA) ? quo_q - 1'b1 : quo_q;
						st_q <= C_MUL;
					end
				end
				C_ROM: begin
					if (n_q >= CNT_W'(rv)) begin
						buf_q[k_q[3:0]] <= sym[6:0] + ccase;
						if (sym[13:7] != 7'd0) begin
							buf_q[4'(k_q + 5'd1)] <= sym[13:7] + ccase;
							k_q <= k_q + 5'd2;
						end else begin
							k_q <= k_q + 5'd1;
						end
						n_q <= n_q - CNT_W'(rv);
					end else if (r_q == 4'd12) begin
						st_q <= C_DONE;
					end else begin
						r_q <= r_q + 4'd1;
					end
				end
				C_DONE: st_q <= C_IDLE;
				default: st_q <= C_IDLE;
			endcase
		end
	end

endmodule

[rtl/list_marker_label_generator.sv]
// top level: counter state, item sequencer and output register
// a break goes straight to the output register, a bullet first picks its glyph;
// an ordered item steps its counter and the digit unit converts the new value,
// then one character per cycle while the output is free; one item at a time, ready
// drops from acceptance until the last character is loaded into the output register
// arst_n clears counters, levels in use and the previous-list flag
module list_marker_label_generator import lmlg_pkg::*; #(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	parameter int ID_WIDTH  = DEF_ID_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// is_break[0], list_id[16:1], level[24:17], ordered[25], start_req[57:26], style[61:58]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_point[15:0], has_number[16], number[47:17]
	output logic [47:0] m_tdata,
	// no_marker
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PREP = 5'b00010,
		S_CONV = 5'b00100,
		S_EMIT = 5'b01000,
		S_ONE  = 5'b10000
	} st_t;

	st_t                 st_q;
	logic [CNT_W-1:0]    cnt_q [MAX_DEPTH];
	logic [LW:0]         inuse_q;
	logic [ID_WIDTH-1:0] lid_q;
	logic                lvalid_q;

	logic [LW-1:0]       lvl_q;
	logic [3:0]          style_q;
	logic                ord_q;
	logic [31:0]         start_q;
	logic [CNT_W-1:0]    num_q;
	logic [4:0]          idx_q;
	logic [4:0]          tot_q;
	logic [15:0]         glyph_q;

	conv_req_t           req;
	conv_sts_t           sts;
	logic [15:0]         cchar;

	// input fields
	logic                in_brk;
	logic [15:0]         in_id;
	logic [7:0]          in_lvl;
	logic [LW-1:0]       lvl_c;
	assign in_brk = s_tdata[0];
	assign in_id  = s_tdata[16:1];
	assign in_lvl = s_tdata[24:17];
	assign lvl_c  = (32'(in_lvl) > MAX_DEPTH - 1) ? LW'(MAX_DEPTH - 1) : LW'(in_lvl);

	assign s_tready = (st_q == S_IDLE);

	logic [ID_WIDTH-1:0] id_c;
	always_comb begin
		id_c = '0;
		for (int b = 0; b < ID_WIDTH; b++) id_c[b] = (b < 16) ? in_id[b] : 1'b0;
	end

	// next counter value of the current level
	logic [CNT_W-1:0] nxt_num;
	always_comb begin
		if (cnt_q[lvl_q] == '0)
			nxt_num = (start_q[31] || start_q == '0) ? CNT_W'(1) : start_q[CNT_W-1:0];
		else if (cnt_q[lvl_q] != CNT_MAX)
			nxt_num = cnt_q[lvl_q] + 1'b1;
		else
			nxt_num = cnt_q[lvl_q];
	end

	// level modulo 3, one bit at a time from the top
	logic [1:0] lvl_m3;
	always_comb begin
		logic [2:0] t;
		lvl_m3 = 2'd0;
		for (int b = LW - 1; b >= 0; b--) begin
			t = {lvl_m3, lvl_q[b]};
			lvl_m3 = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
		end
	end

	lmlg_conv u_conv (
		.clk(clk), .arst_n(arst_n), .req(req), .sts(sts),
		.rd_idx(idx_q[3:0]), .rd_char(cchar)
	);

	// conversion request
	always_comb begin
		req.start = (st_q == S_PREP) && ord_q;
		req.value = nxt_num;
		req.upper = (style_q == ST_UALPHA) || (style_q == ST_UROMAN);
		case (style_q)
			ST_LALPHA, ST_UALPHA: req.mode = MD_ALPHA;
			ST_LROMAN, ST_UROMAN: req.mode = MD_ROMAN;
			default:              req.mode = MD_DEC;
		endcase
	end

	logic out_free;
	logic emit_ld;
	assign out_free = !m_tvalid || m_tready;
	assign emit_ld  = out_free && ((st_q == S_EMIT) || (st_q == S_ONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			inuse_q  <= '0;
			lid_q    <= '0;
			lvalid_q <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++) cnt_q[i] <= '0;
		end else begin
			if (!emit_ld && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ord_q   <= s_tdata[25];
						start_q <= s_tdata[57:26];
						style_q <= s_tdata[61:58];
						lvl_q   <= lvl_c;
						if (in_brk) begin
							for (int i = 0; i < MAX_DEPTH; i++) cnt_q[i] <= '0;
							inuse_q  <= '0;
							lvalid_q <= 1'b0;
							glyph_q  <= '0;
							st_q     <= S_ONE;
						end else begin
							// list change clears, deeper levels cleared
							for (int i = 0; i < MAX_DEPTH; i++)
								if ((!lvalid_q || lid_q != id_c) || i > 32'(lvl_c))
									cnt_q[i] <= '0;
							inuse_q  <= (LW+1)'(lvl_c) + 1'b1;
							lid_q    <= id_c;
							lvalid_q <= 1'b1;
							st_q     <= S_PREP;
						end
					end
				end
				S_PREP: begin
					if (ord_q) begin
						cnt_q[lvl_q] <= nxt_num;
						num_q        <= nxt_num;
						st_q         <= S_CONV;
					end else begin
						case (style_q)
							ST_DISC:   glyph_q <= GL_DISC;
							ST_CIRCLE: glyph_q <= GL_CIRCLE;
							ST_SQUARE: glyph_q <= GL_SQUARE;
							ST_DASH:   glyph_q <= GL_DASH;
							default: begin
								case (lvl_m3)
									2'd0:    glyph_q <= GL_DISC;
									2'd1:    glyph_q <= GL_CIRCLE;
									default: glyph_q <= GL_SQUARE;
								endcase
							end
						endcase
						st_q <= S_ONE;
					end
				end
				S_CONV: begin
					if (sts.done) begin
						idx_q <= '0;
						tot_q <= sts.count;
						st_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					// one character transfer per free output slot, then the dot
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= 1'b0;
						m_tdata  <= {num_q, 1'b1, (idx_q == tot_q) ? CH_DOT : cchar};
						m_tlast  <= (idx_q == tot_q);
						idx_q    <= idx_q + 5'd1;
						if (idx_q == tot_q) st_q <= S_IDLE;
					end
				end
				S_ONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= (glyph_q == '0);
						m_tdata  <= {31'd0, 1'b0, glyph_q};
						m_tlast  <= 1'b1;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic unused_in;
	assign unused_in = ^{s_tdata[63:62], inuse_q};

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (st_q == S_IDLE)) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("output dropped");
	a_brk_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[16] == 1'b0)) else $error("break result");

endmodule
